// ===== hw/rtl/i2c_mrs_pkg.sv =====
// ----------------------------------------------------------------------------
// i2c_mrs_pkg
// Opcodes and the result record shared by the register sequencer and the testbench.
// ----------------------------------------------------------------------------
package i2c_mrs_pkg;

    typedef logic [2:0] t_opcode;

    localparam t_opcode OP_LOAD     = 3'd0;
    localparam t_opcode OP_START_WR = 3'd1;
    localparam t_opcode OP_START_RD = 3'd2;
    localparam t_opcode OP_TX_EMPTY = 3'd3;
    localparam t_opcode OP_RX_VALID = 3'd4;

    // one result record per event
    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       send_start;
        logic       send_stop;
        logic       send_nack;
        logic       send_abort;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic [4:0] rx_index;
        logic       receive_phase;
        logic       busy_res;
        logic       rejected;
    } t_result;

endpackage

// ===== hw/rtl/i2c_master_register_sequencer.sv =====
// ----------------------------------------------------------------------------
// i2c_master_register_sequencer
// Event-driven sequencer issuing register writes and reads to an I2C master.
// ----------------------------------------------------------------------------
// Usage: each input transfer carries one event (payload load, start write,
// start read, transmit-empty or receive-valid) and yields exactly one result
// transfer with the controller commands, the byte to transmit and any
// received byte. Payload bytes live in a buffer memory with one write port
// and a registered read; the device and register header bytes are kept in
// flops. A result passes through the buffer-read stage and then the output
// register. Throughput is one event per cycle while the result side keeps
// up; control state updates in the accept cycle so the next event sees it at
// once, and the buffer read and write of neighboring events never collide.
// When the receiver stalls, the output register holds its result and the
// middle stage holds the next; input ready drops only when both are full.
// Reset returns the sequencer to idle and empties the pipeline; the payload
// buffer is not cleared and must be loaded before a write sends it.
// ----------------------------------------------------------------------------
module i2c_master_register_sequencer #(
    parameter int SEND_DEPTH = 32,
    parameter int RECV_LIMIT = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [2:0] i_opcode,
    input  logic [6:0] i_dev_addr,
    input  logic [7:0] i_reg_num,
    input  logic [7:0] i_length,
    input  logic [7:0] i_data_byte,
    input  logic [4:0] i_byte_index,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_tx_valid,
    output logic [7:0] o_tx_byte,
    output logic       o_send_start,
    output logic       o_send_stop,
    output logic       o_send_nack,
    output logic       o_send_abort,
    output logic       o_rx_valid,
    output logic [7:0] o_rx_byte,
    output logic [4:0] o_rx_index,
    output logic       o_receive_phase,
    output logic       o_busy_res,
    output logic       o_rejected
);

    localparam int PD = SEND_DEPTH - 2;
    localparam int AW = (PD > 1) ? $clog2(PD) : 1;
    localparam int CW = $clog2(SEND_DEPTH + 1);
    localparam int RW = $clog2(RECV_LIMIT + 1);

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_WRITE  = 3'd1;
    localparam logic [2:0] PH_ADDR_W = 3'd2;
    localparam logic [2:0] PH_REG    = 3'd3;
    localparam logic [2:0] PH_ADDR_R = 3'd4;
    localparam logic [2:0] PH_FINISH = 3'd5;
    localparam logic [2:0] PH_RECV   = 3'd6;

    logic [7:0]    r_mem [PD];
    logic [7:0]    r_rd_data;

    logic [2:0]    r_phase, n_phase;
    logic [CW-1:0] r_send_count, n_send_count;
    logic [CW-1:0] r_send_pos, n_send_pos;
    logic [RW-1:0] r_recv_count, n_recv_count;
    logic [RW-1:0] r_recv_pos, n_recv_pos;
    logic [6:0]    r_dev, n_dev;
    logic [7:0]    r_reg, n_reg;

    logic                  r_s1_valid;
    logic                  r_s1_use_mem;
    i2c_mrs_pkg::t_result  r_s1;
    logic                  r_out_valid;
    i2c_mrs_pkg::t_result  r_out;

    i2c_mrs_pkg::t_result  res;
    i2c_mrs_pkg::t_result  s1_res;
    logic                  use_mem;
    logic                  accept;
    logic                  s1_move;
    logic                  load_wr;
    logic [AW-1:0]         wr_addr;
    logic [AW-1:0]         rd_addr;
    logic [CW-1:0]         pos_off;
    logic [AW+4:0]         wr_ext;
    logic [9:0]            wr_len;
    logic [8:0]            slot_sum;
    logic [RW+4:0]         rx_ext;

    assign s1_move    = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_move;
    assign accept     = i_in_valid && o_in_ready;

    // payload slot index+2 goes to buffer entry index
    assign slot_sum = {4'b0, i_byte_index} + 9'd2;
    assign wr_ext   = {{AW{1'b0}}, i_byte_index};
    assign wr_addr  = wr_ext[AW-1:0];
    assign load_wr  = accept && (i2c_mrs_pkg::t_opcode'(i_opcode) == i2c_mrs_pkg::OP_LOAD)
                      && (slot_sum < 9'(SEND_DEPTH));
    assign pos_off  = r_send_pos - CW'(2);
    assign rd_addr  = pos_off[AW-1:0];
    assign wr_len   = {2'b0, i_length} + 10'd2;
    assign rx_ext   = {5'b0, r_recv_pos};

    always_comb begin
        n_phase      = r_phase;
        n_send_count = r_send_count;
        n_send_pos   = r_send_pos;
        n_recv_count = r_recv_count;
        n_recv_pos   = r_recv_pos;
        n_dev        = r_dev;
        n_reg        = r_reg;
        res          = '0;
        use_mem      = 1'b0;
        unique case (i2c_mrs_pkg::t_opcode'(i_opcode))
            i2c_mrs_pkg::OP_START_WR, i2c_mrs_pkg::OP_START_RD: begin
                if (r_phase != PH_IDLE) begin
                    res.rejected = 1'b1;
                end else begin
                    res.send_abort = 1'b1;
                    res.send_start = 1'b1;
                    n_dev          = i_dev_addr;
                    n_reg          = i_reg_num;
                    n_send_pos     = '0;
                    if (i2c_mrs_pkg::t_opcode'(i_opcode) == i2c_mrs_pkg::OP_START_WR) begin
                        n_send_count = (wr_len > 10'(SEND_DEPTH)) ? CW'(SEND_DEPTH)
                                                                  : CW'(wr_len);
                        n_phase      = PH_WRITE;
                    end else begin
                        n_send_count = CW'(3);
                        n_recv_count = ({1'b0, i_length} > 9'(RECV_LIMIT)) ? RW'(RECV_LIMIT)
                                                                           : RW'(i_length);
                        n_recv_pos   = '0;
                        n_phase      = PH_ADDR_W;
                    end
                end
            end
            i2c_mrs_pkg::OP_TX_EMPTY: begin
                unique case (r_phase)
                    PH_WRITE, PH_ADDR_W, PH_REG: begin
                        if (r_phase != PH_WRITE || r_send_pos < r_send_count) begin
                            res.tx_valid = 1'b1;
                            n_send_pos   = r_send_pos + CW'(1);
                            if (r_send_pos == CW'(0)) begin
                                res.tx_byte = {r_dev, 1'b0};
                            end else if (r_send_pos == CW'(1)) begin
                                res.tx_byte = r_reg;
                            end else begin
                                use_mem = 1'b1;
                            end
                            if (r_phase == PH_ADDR_W) n_phase = PH_REG;
                            if (r_phase == PH_REG)    n_phase = PH_ADDR_R;
                        end else begin
                            res.send_stop = 1'b1;
                            n_phase       = PH_IDLE;
                        end
                    end
                    PH_ADDR_R: begin
                        res.send_start = 1'b1;
                        res.tx_valid   = 1'b1;
                        res.tx_byte    = {r_dev, 1'b1};
                        n_send_pos     = r_send_pos + CW'(1);
                        n_phase        = PH_FINISH;
                    end
                    PH_FINISH: begin
                        n_phase = PH_RECV;
                    end
                    default: begin
                    end
                endcase
            end
            i2c_mrs_pkg::OP_RX_VALID: begin
                if (r_phase == PH_RECV) begin
                    if (r_recv_pos < r_recv_count) begin
                        res.rx_valid = 1'b1;
                        res.rx_byte  = i_data_byte;
                        res.rx_index = rx_ext[4:0];
                        n_recv_pos   = r_recv_pos + RW'(1);
                        if (n_recv_pos >= r_recv_count) res.send_nack = 1'b1;
                    end else begin
                        res.send_stop = 1'b1;
                        n_phase       = PH_IDLE;
                    end
                end
            end
            default: begin
            end
        endcase
        res.receive_phase = (n_phase == PH_RECV);
        res.busy_res      = (n_phase != PH_IDLE);
    end

    // payload bytes come from the buffer read that is registered with the transfer
    always_comb begin
        s1_res = r_s1;
        if (r_s1_use_mem) s1_res.tx_byte = r_rd_data;
    end

    // payload buffer: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (load_wr) begin
            r_mem[wr_addr] <= i_data_byte;
        end
        if (accept) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_send_count <= '0;
            r_send_pos   <= '0;
            r_recv_count <= '0;
            r_recv_pos   <= '0;
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (accept) begin
                r_phase      <= n_phase;
                r_send_count <= n_send_count;
                r_send_pos   <= n_send_pos;
                r_recv_count <= n_recv_count;
                r_recv_pos   <= n_recv_pos;
                r_s1_valid   <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_dev        <= n_dev;
            r_reg        <= n_reg;
            r_s1         <= res;
            r_s1_use_mem <= use_mem;
        end
        if (s1_move) begin
            r_out <= s1_res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_tx_valid      = r_out.tx_valid;
    assign o_tx_byte       = r_out.tx_byte;
    assign o_send_start    = r_out.send_start;
    assign o_send_stop     = r_out.send_stop;
    assign o_send_nack     = r_out.send_nack;
    assign o_send_abort    = r_out.send_abort;
    assign o_rx_valid      = r_out.rx_valid;
    assign o_rx_byte       = r_out.rx_byte;
    assign o_rx_index      = r_out.rx_index;
    assign o_receive_phase = r_out.receive_phase;
    assign o_busy_res      = r_out.busy_res;
    assign o_rejected      = r_out.rejected;

endmodule

// ===== hw/rtl/i2c_mrs_checker.sv =====
// ----------------------------------------------------------------------------
// i2c_mrs_checker
// Port-level checks on the register sequencer's result channel.
// ----------------------------------------------------------------------------
module i2c_mrs_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       o_out_valid,
    input  logic       i_out_ready,
    input  logic       o_tx_valid,
    input  logic [7:0] o_tx_byte,
    input  logic       o_send_start,
    input  logic       o_send_stop,
    input  logic       o_send_abort,
    input  logic       o_rx_valid,
    input  logic [7:0] o_rx_byte,
    input  logic       o_receive_phase,
    input  logic       o_busy_res,
    input  logic       o_rejected
);

    // a start that is taken opens a transaction
    a_abort_opens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_send_abort |-> o_send_start && o_busy_res && !o_rejected)
        else $error("abort without start or busy");

    // stop always ends the transaction
    a_stop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_send_stop |-> !o_busy_res && !o_tx_valid && !o_rx_valid)
        else $error("stop while still busy");

    // receive phase is part of a busy transaction
    a_recv_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_receive_phase || o_rx_valid) |-> o_busy_res && !o_tx_valid)
        else $error("receive outside a transaction");

    // a rejected start changes nothing about the busy state
    a_reject_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_rejected |-> o_busy_res && !o_send_start)
        else $error("rejected start while idle");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_tx_byte)
        && $stable(o_rx_byte) && $stable(o_busy_res))
        else $error("stalled result changed");

endmodule

bind i2c_master_register_sequencer i2c_mrs_checker u_i2c_mrs_checker (.*);

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the i2c register sequencer. Directed events
// cover the buffer fill, ignored loads and opcodes, and events that arrive in
// the wrong phase. They also cover rejected starts, zero-length and short
// reads, and loads into a running write. Random write and read transactions
// follow, with stray events and cut-short sequences mixed in. A scoreboard
// predicts every result and compares it field by field.
// ----------------------------------------------------------------------------
module testbench;

    localparam int SEND_DEPTH   = 32;
    localparam int RECV_LIMIT   = 32;
    localparam int RESET_CYCLES = 6;
    localparam int ITEM_TARGET  = 1500;
    localparam int QUIET_ITEMS  = 200;
    localparam int HOLD_CYCLES  = 300;
    localparam int STEP_CAP     = 1000;
    localparam int TAIL_CYCLES  = 8;
    localparam int CYCLE_LIMIT  = 500000;

    localparam i2c_mrs_pkg::t_opcode OP_SPARE_LO = 3'd5;
    localparam i2c_mrs_pkg::t_opcode OP_SPARE_HI = 3'd7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAYLOAD,
        ST_DEV_WR,
        ST_REG,
        ST_DEV_RD,
        ST_TURN,
        ST_RECV
    } t_seq_phase;

    typedef struct {
        i2c_mrs_pkg::t_opcode op;
        logic [6:0]           dev;
        logic [7:0]           reg_num;
        logic [7:0]           len;
        logic [7:0]           data;
        logic [4:0]           idx;
    } t_event;

    class seq_scoreboard;
        t_seq_phase           phase;
        logic [7:0]           payload [SEND_DEPTH];
        int unsigned          tx_total;
        int unsigned          tx_pos;
        int unsigned          rx_total;
        int unsigned          rx_pos;
        i2c_mrs_pkg::t_result expected_q [$];
        int unsigned          errors;
        int unsigned          n_writes;
        int unsigned          n_reads;
        int unsigned          n_rx_bytes;
        int unsigned          n_rejects;
        int unsigned          n_checked;

        function new();
            phase = ST_IDLE;
            foreach (payload[i]) payload[i] = 8'h00;
            tx_total = 0;
            tx_pos = 0;
            rx_total = 0;
            rx_pos = 0;
            errors = 0;
            n_writes = 0;
            n_reads = 0;
            n_rx_bytes = 0;
            n_rejects = 0;
            n_checked = 0;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        // predicts the result of one accepted event; returns 1 if it did anything
        function bit note_event(t_event ev);
            i2c_mrs_pkg::t_result r;
            t_seq_phase           was;
            bit                   acted;
            r = '0;
            was = phase;
            acted = 1'b0;
            case (ev.op)
                i2c_mrs_pkg::OP_LOAD: begin
                    if (int'(ev.idx) + 2 < SEND_DEPTH) begin
                        payload[int'(ev.idx) + 2] = ev.data;
                        acted = 1'b1;
                    end
                end
                i2c_mrs_pkg::OP_START_WR, i2c_mrs_pkg::OP_START_RD: begin
                    if (phase != ST_IDLE) begin
                        r.rejected = 1'b1;
                        n_rejects++;
                    end else begin
                        r.send_abort = 1'b1;
                        r.send_start = 1'b1;
                        payload[0] = {ev.dev, 1'b0};
                        payload[1] = ev.reg_num;
                        tx_pos = 0;
                        if (ev.op == i2c_mrs_pkg::OP_START_WR) begin
                            tx_total = (int'(ev.len) + 2 > SEND_DEPTH) ?
                                       SEND_DEPTH : int'(ev.len) + 2;
                            phase = ST_PAYLOAD;
                            n_writes++;
                        end else begin
                            tx_total = 3;
                            rx_total = (int'(ev.len) > RECV_LIMIT) ? RECV_LIMIT : int'(ev.len);
                            rx_pos = 0;
                            phase = ST_DEV_WR;
                            n_reads++;
                        end
                    end
                end
                i2c_mrs_pkg::OP_TX_EMPTY: begin
                    case (phase)
                        ST_PAYLOAD: begin
                            if (tx_pos < tx_total) begin
                                r.tx_valid = 1'b1;
                                r.tx_byte = payload[tx_pos];
                                tx_pos++;
                            end else begin
                                r.send_stop = 1'b1;
                                phase = ST_IDLE;
                            end
                        end
                        ST_DEV_WR, ST_REG: begin
                            r.tx_valid = 1'b1;
                            r.tx_byte = payload[tx_pos];
                            tx_pos++;
                            phase = (phase == ST_DEV_WR) ? ST_REG : ST_DEV_RD;
                        end
                        ST_DEV_RD: begin
                            // repeated start with the read address
                            r.send_start = 1'b1;
                            r.tx_valid = 1'b1;
                            r.tx_byte = payload[0] | 8'h01;
                            tx_pos++;
                            phase = ST_TURN;
                        end
                        ST_TURN: begin
                            phase = ST_RECV;
                        end
                        default: ;
                    endcase
                end
                i2c_mrs_pkg::OP_RX_VALID: begin
                    if (phase == ST_RECV) begin
                        if (rx_pos < rx_total) begin
                            r.rx_valid = 1'b1;
                            r.rx_byte = ev.data;
                            r.rx_index = rx_pos[4:0];
                            rx_pos++;
                            if (rx_pos >= rx_total) r.send_nack = 1'b1;
                            n_rx_bytes++;
                        end else begin
                            r.send_stop = 1'b1;
                            phase = ST_IDLE;
                        end
                    end
                end
                default: ;
            endcase
            r.receive_phase = (phase == ST_RECV);
            r.busy_res = (phase != ST_IDLE);
            expected_q.push_back(r);
            return acted || (phase != was) || r.tx_valid || r.rx_valid || r.send_stop
                   || r.rejected || r.send_start;
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (want !== got) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(i2c_mrs_pkg::t_result got);
            i2c_mrs_pkg::t_result want;
            if (expected_q.size() == 0) begin
                $error("result transfer with nothing expected: %p", got);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            n_checked++;
            compare_field("tx_valid", want.tx_valid, got.tx_valid);
            compare_field("tx_byte", want.tx_byte, got.tx_byte);
            compare_field("send_start", want.send_start, got.send_start);
            compare_field("send_stop", want.send_stop, got.send_stop);
            compare_field("send_nack", want.send_nack, got.send_nack);
            compare_field("send_abort", want.send_abort, got.send_abort);
            compare_field("rx_valid", want.rx_valid, got.rx_valid);
            compare_field("rx_byte", want.rx_byte, got.rx_byte);
            compare_field("rx_index", want.rx_index, got.rx_index);
            compare_field("receive_phase", want.receive_phase, got.receive_phase);
            compare_field("busy_res", want.busy_res, got.busy_res);
            compare_field("rejected", want.rejected, got.rejected);
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    logic [2:0] i_opcode;
    logic [6:0] i_dev_addr;
    logic [7:0] i_reg_num;
    logic [7:0] i_length;
    logic [7:0] i_data_byte;
    logic [4:0] i_byte_index;
    logic       o_out_valid;
    logic       i_out_ready;
    logic       o_tx_valid;
    logic [7:0] o_tx_byte;
    logic       o_send_start;
    logic       o_send_stop;
    logic       o_send_nack;
    logic       o_send_abort;
    logic       o_rx_valid;
    logic [7:0] o_rx_byte;
    logic [4:0] o_rx_index;
    logic       o_receive_phase;
    logic       o_busy_res;
    logic       o_rejected;

    i2c_mrs_pkg::t_result observed;
    seq_scoreboard        sb;
    bit                   quiet;
    bit                   hold_request;
    int unsigned          n_items;
    int unsigned          n_events;

    i2c_master_register_sequencer #(
        .SEND_DEPTH (SEND_DEPTH),
        .RECV_LIMIT (RECV_LIMIT)
    ) u_top (.*);

    assign observed = {o_tx_valid, o_tx_byte, o_send_start, o_send_stop, o_send_nack,
                       o_send_abort, o_rx_valid, o_rx_byte, o_rx_index, o_receive_phase,
                       o_busy_res, o_rejected};

    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_result(observed);
        end
    end

    // result side: random stalls, one long hold-off on request
    initial begin : result_side
        int unsigned stall_left;
        stall_left = 0;
        i_out_ready <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_out_ready <= 1'b1;
            end else begin
                if (!quiet && stall_left == 0 && $urandom_range(0, 9) == 0) begin
                    stall_left = $urandom_range(1, 12);
                end
                if (quiet) stall_left = 0;
                if (stall_left > 0) begin
                    i_out_ready <= 1'b0;
                    stall_left--;
                end else begin
                    i_out_ready <= 1'b1;
                end
            end
        end
    end

    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("i2c_master_register_sequencer test failed");
        $finish;
    end

    // drives one event and waits for its transfer; negative arguments mean random
    task automatic issue(i2c_mrs_pkg::t_opcode op, int dev = -1, int reg_num = -1,
                         int len = -1, int data = -1, int idx = -1);
        t_event ev;
        ev.op      = op;
        ev.dev     = (dev < 0) ? 7'($urandom_range(0, 127)) : 7'(dev);
        ev.reg_num = (reg_num < 0) ? 8'($urandom_range(0, 255)) : 8'(reg_num);
        ev.len     = (len < 0) ? 8'($urandom_range(0, 255)) : 8'(len);
        ev.data    = (data < 0) ? 8'($urandom_range(0, 255)) : 8'(data);
        ev.idx     = (idx < 0) ? 5'($urandom_range(0, 31)) : 5'(idx);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_opcode     <= ev.op;
        i_dev_addr   <= ev.dev;
        i_reg_num    <= ev.reg_num;
        i_length     <= ev.len;
        i_data_byte  <= ev.data;
        i_byte_index <= ev.idx;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        n_events++;
        if (sb.note_event(ev)) n_items++;
    endtask

    task automatic issue_noise();
        case ($urandom_range(0, 4))
            0: issue(i2c_mrs_pkg::t_opcode'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)));
            1: issue(i2c_mrs_pkg::OP_LOAD);
            2: issue(i2c_mrs_pkg::OP_TX_EMPTY);
            3: issue(i2c_mrs_pkg::OP_RX_VALID);
            default: issue($urandom_range(0, 1) ? i2c_mrs_pkg::OP_START_WR
                                                : i2c_mrs_pkg::OP_START_RD);
        endcase
    endtask

    // steps the running transaction toward its stop, with stray events mixed in
    task automatic finish_txn(int cut);
        int steps;
        steps = 0;
        while (sb.phase != ST_IDLE && steps < cut) begin
            if ($urandom_range(0, 9) == 0) issue_noise();
            issue((sb.phase == ST_RECV) ? i2c_mrs_pkg::OP_RX_VALID
                                        : i2c_mrs_pkg::OP_TX_EMPTY);
            steps++;
        end
    endtask

    task automatic wait_results_done();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    initial begin : stimulus
        int  len;
        int  cut;
        int  pick;
        bit  held;
        bit  paused;
        sb = new();
        quiet = 1'b0;
        hold_request = 1'b0;
        held = 1'b0;
        paused = 1'b0;
        n_items = 0;
        n_events = 0;
        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_opcode     <= i2c_mrs_pkg::OP_LOAD;
        i_dev_addr   <= '0;
        i_reg_num    <= '0;
        i_length     <= '0;
        i_data_byte  <= '0;
        i_byte_index <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // fill every payload slot so no write ever sends an unwritten one
        for (int i = 0; i < SEND_DEPTH - 2; i++) issue(i2c_mrs_pkg::OP_LOAD, .idx(i));

        // directed events
        issue(i2c_mrs_pkg::OP_LOAD, .idx(30), .data(8'hFF));
        issue(i2c_mrs_pkg::OP_LOAD, .idx(31), .data(8'h00));
        issue(OP_SPARE_LO);
        issue(OP_SPARE_HI);
        issue(i2c_mrs_pkg::OP_TX_EMPTY);
        issue(i2c_mrs_pkg::OP_RX_VALID);
        issue(i2c_mrs_pkg::OP_LOAD, .idx(29), .data(8'hFF));
        issue(i2c_mrs_pkg::OP_START_WR, .dev(127), .reg_num(8'hFF), .len(0));
        issue(i2c_mrs_pkg::OP_START_RD);
        repeat (3) issue(i2c_mrs_pkg::OP_TX_EMPTY);
        // load into a running write changes the byte still to go out
        issue(i2c_mrs_pkg::OP_START_WR, .dev(0), .reg_num(0), .len(1));
        issue(i2c_mrs_pkg::OP_LOAD, .idx(0), .data(8'h00));
        repeat (4) issue(i2c_mrs_pkg::OP_TX_EMPTY);
        // zero-length read
        issue(i2c_mrs_pkg::OP_START_RD, .dev(0), .reg_num(0), .len(0));
        repeat (3) issue(i2c_mrs_pkg::OP_TX_EMPTY);
        issue(i2c_mrs_pkg::OP_RX_VALID);
        issue(i2c_mrs_pkg::OP_TX_EMPTY);
        issue(i2c_mrs_pkg::OP_TX_EMPTY);
        issue(i2c_mrs_pkg::OP_RX_VALID);
        // short read with a start refused while receiving
        issue(i2c_mrs_pkg::OP_START_RD, .dev(127), .reg_num(8'hFF), .len(1));
        repeat (4) issue(i2c_mrs_pkg::OP_TX_EMPTY);
        issue(i2c_mrs_pkg::OP_START_WR);
        issue(i2c_mrs_pkg::OP_RX_VALID, .data(8'hFF));
        issue(i2c_mrs_pkg::OP_RX_VALID);

        // random transactions
        while (n_events < ITEM_TARGET) begin
            if (n_events >= ITEM_TARGET - QUIET_ITEMS) quiet = 1'b1;
            if (!held && n_events >= 400) begin
                hold_request = 1'b1;
                held = 1'b1;
            end
            if (!paused && n_events >= 900) begin
                wait_results_done();
                paused = 1'b1;
            end
            finish_txn(STEP_CAP);
            pick = $urandom_range(0, 99);
            if (pick < 84) begin
                case ($urandom_range(0, 19))
                    0:       len = $urandom_range(0, 255);
                    1, 2, 3: len = $urandom_range(0, 40);
                    default: len = $urandom_range(0, 6);
                endcase
                cut = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 5) : STEP_CAP;
                issue((pick < 42) ? i2c_mrs_pkg::OP_START_WR : i2c_mrs_pkg::OP_START_RD,
                      .len(len));
                finish_txn(cut);
            end else begin
                repeat ($urandom_range(1, 4)) issue_noise();
            end
        end
        finish_txn(STEP_CAP);

        wait_results_done();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("covered %0d writes and %0d reads, %0d bytes received, %0d starts refused",
                 sb.n_writes, sb.n_reads, sb.n_rx_bytes, sb.n_rejects);
        $display("%0d events sent (%0d with an effect), %0d results checked, with a drain",
                 n_events, n_items, sb.n_checked);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("i2c_master_register_sequencer test passed");
        end else begin
            $display("i2c_master_register_sequencer test failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/i2c_mrs_pkg.sv
hw/rtl/i2c_master_register_sequencer.sv
hw/rtl/i2c_mrs_checker.sv
test/testbench.sv
